// ----- hw/rtl/utfr_pkg.sv -----
// ============================================================================
// UTF-8 replacer package
// Shared constants, result entry type and lead byte decode.
// ============================================================================
package utfr_pkg;

    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    localparam int MAX_RES   = 4;
    localparam int HELD_MAX  = 3;
    localparam int FIFO_DEPTH = 2;

    // One transaction's worth of output bytes, first byte in slot 0
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] res_bytes;
        logic [2:0]              res_count;
        logic                    res_last;
    } t_entry;

    // Sequence length opened by a lead byte; zero when the byte opens none
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            len = 3'd2;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            len = 3'd3;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ----- hw/rtl/utf8_invalid_byte_replacer.sv -----
// ============================================================================
// UTF-8 invalid byte replacer
// Passes valid UTF-8 sequences whole and replaces each byte of a broken sequence, and each stray byte, with '?'.
// ============================================================================
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------
//  input   | i_in_valid   | o_in_stall   | i_in_byte, i_in_last
//  output  | o_out_valid  | i_out_stall  | o_out_byte, o_out_last
//
//  The front end takes one byte per cycle while the two-entry queue has room.
//  The back end sends one output byte per cycle while i_out_stall is low, so
//  a byte that releases n results (up to 4) sends n output bytes; that port
//  sets rate. First output passes the queue, then the back end entry register.
//  Synchronous active-low reset empties the queue and any open sequence.
//  Output stalls back up through the queue to o_in_stall.
// ============================================================================
module utf8_invalid_byte_replacer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    utfr_pkg::t_entry w_push_ent;
    utfr_pkg::t_entry w_head_ent;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic             w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    utfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_push   (w_push),
        .o_entry  (w_push_ent)
    );

    utfr_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_ent),
        .i_pop    (w_pop),
        .o_entry  (w_head_ent),
        .o_full   (w_full),
        .o_empty  (w_empty)
    );

    utfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_head_ent),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_byte   (o_out_byte),
        .o_last   (o_out_last)
    );

`ifndef ASSERT_OFF
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_push_reaches_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_empty && !o_out_valid) |-> ##2 o_out_valid)
        else $error("pushed entry did not reach output");
`endif

endmodule

// ----- hw/rtl/utfr_front.sv -----
// ============================================================================
// UTF-8 replacer front end
// Tracks the open sequence and turns each input byte into at most one result entry.
// ============================================================================
module utfr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output logic                 o_push,
    output utfr_pkg::t_entry     o_entry
);

    logic [7:0] r_held [utfr_pkg::HELD_MAX];
    logic [1:0] r_hc;
    logic [2:0] r_sl;
    logic [1:0] n_hc;
    logic [2:0] n_sl;

    logic       w_have;
    logic       w_cont;
    logic       w_compl;
    logic       w_store;
    logic       w_start;
    logic [2:0] w_len;
    logic       w_ascii;
    logic       w_lead;
    logic [2:0] w_hc3;

    // Classify the byte against the open sequence
    always_comb begin
        w_hc3   = {1'b0, r_hc};
        w_have  = (r_hc != 2'd0);
        w_cont  = (i_byte[7:6] == utfr_pkg::CONT_TAG);
        w_compl = w_have && w_cont && ((w_hc3 + 3'd1) >= r_sl);
        w_store = w_have && w_cont && !w_compl;
        w_start = !(w_have && w_cont);
        w_len   = utfr_pkg::lead_len(i_byte);
        w_ascii = !i_byte[7];
        w_lead  = (w_len != 3'd0);
    end

    // Build the result entry
    always_comb begin
        o_entry = '0;
        for (int k = 0; k < utfr_pkg::MAX_RES; k++) begin
            if (k == int'(r_hc)) begin
                o_entry.res_bytes[k] = (w_compl || (w_start && w_ascii)) ?
                                       i_byte : utfr_pkg::QMARK;
            end else begin
                o_entry.res_bytes[k] = utfr_pkg::QMARK;
            end
        end
        // Pass the held bytes ahead of the completing byte
        for (int k = 0; k < utfr_pkg::HELD_MAX; k++) begin
            if (w_compl && (k < int'(r_hc))) begin
                o_entry.res_bytes[k] = r_held[k];
            end
        end
        if (w_compl) begin
            o_entry.res_count = w_hc3 + 3'd1;
        end else if (w_store) begin
            o_entry.res_count = i_last ? (w_hc3 + 3'd1) : 3'd0;
        end else begin
            o_entry.res_count = w_hc3 + (w_lead ? {2'b00, i_last} : 3'd1);
        end
        o_entry.res_last = i_last;
        o_push = i_accept && (o_entry.res_count != 3'd0);
    end

    // Advance the sequence state
    always_comb begin
        n_hc = r_hc;
        n_sl = r_sl;
        if (w_compl) begin
            n_hc = 2'd0;
            n_sl = 3'd0;
        end else if (w_store) begin
            n_hc = i_last ? 2'd0 : (r_hc + 2'd1);
            n_sl = i_last ? 3'd0 : r_sl;
        end else if (w_lead && !i_last) begin
            n_hc = 2'd1;
            n_sl = w_len;
        end else begin
            n_hc = 2'd0;
            n_sl = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 2'd0;
            r_sl <= 3'd0;
        end else if (i_accept) begin
            r_hc <= n_hc;
            r_sl <= n_sl;
        end
    end

    // Hold sequence bytes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (w_store) begin
                r_held[r_hc] <= i_byte;
            end else if (w_start && w_lead) begin
                r_held[0] <= i_byte;
            end
        end
    end

endmodule

// ----- hw/rtl/utfr_fifo.sv -----
// ============================================================================
// UTF-8 replacer entry queue
// Two-entry queue of result entries between front end and back end.
// ============================================================================
module utfr_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utfr_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output utfr_pkg::t_entry     o_entry,
    output logic                 o_full,
    output logic                 o_empty
);

    utfr_pkg::t_entry r_mem [utfr_pkg::FIFO_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'(utfr_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hw/rtl/utfr_back.sv -----
// ============================================================================
// UTF-8 replacer back end
// Unpacks each result entry into single output byte transactions.
// ============================================================================
module utfr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  utfr_pkg::t_entry     i_entry,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_byte,
    output logic                 o_last
);

    utfr_pkg::t_entry r_ent;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic [1:0]       w_end_idx;
    logic             w_at_end;
    logic             w_fire;
    logic [2:0]       w_cnt_m1;

    // Locate the final byte of the current entry
    always_comb begin
        w_cnt_m1  = r_ent.res_count - 3'd1;
        w_end_idx = w_cnt_m1[1:0];
        w_at_end  = (r_idx == w_end_idx);
        w_fire    = r_busy && !i_stall;
        o_pop     = (!r_busy || (w_fire && w_at_end)) && !i_empty;
    end

    assign o_valid = r_busy;
    assign o_byte  = r_ent.res_bytes[r_idx];
    assign o_last  = r_ent.res_last && w_at_end;

    // Advance through the entry, load the next one at its end or when idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_fire) begin
            if (w_at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

endmodule
